[rtl/vwcif_pkg.sv]
// Shared types and constants for the variant window CpG / indel flagger.
`default_nettype none

package vwcif_pkg;

    // Default build parameters
    localparam int WINDOW_DEPTH_DEF  = 16;
    localparam int POSITION_BITS_DEF = 32;

    // Configuration register reset value (read_ahead)
    localparam logic [3:0] READ_AHEAD_RST = 4'd5;

    // Stream beat widths (fields packed from bit 0, padded to whole bytes)
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 80;

    // Bit positions inside the per-entry mark nibble
    localparam int MK_C     = 0;
    localparam int MK_G     = 1;
    localparam int MK_INDEL = 2;
    localparam int MK_CPG   = 3;

    // One incoming record
    typedef struct packed {
        logic [31:0] position;
        logic [7:0]  chrom_id;
        logic        has_c;
        logic        has_g;
        logic        is_indel;
        logic [31:0] record_tag;
        logic        end_of_stream;
    } t_rec_in;

    // One released record
    typedef struct packed {
        logic [31:0] out_position;
        logic [7:0]  out_chrom_id;
        logic [31:0] out_tag;
        logic        out_is_indel;
        logic        cpg_flag;
        logic        close_indel_flag;
        logic        last_of_run;
    } t_rec_out;

endpackage

`default_nettype wire

[rtl/vwcif_window_ram.sv]
// Window record store: one write port, one read port, registered read data.
`default_nettype none

module vwcif_window_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 76
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/vwcif_ctrl.sv]
// Window sequencer: CpG marking, record insert, release scan and result register.
`default_nettype none

module vwcif_ctrl
    import vwcif_pkg::*;
#(
    parameter int DEPTH = WINDOW_DEPTH_DEF,
    parameter int PB    = POSITION_BITS_DEF,
    parameter int EW    = POSITION_BITS_DEF + 44
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic [3:0]               i_read_ahead,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire t_rec_in                  i_rec,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output t_rec_out                      o_rec,
    output logic                          o_ram_we,
    output logic [$clog2(DEPTH)-1:0]      o_ram_waddr,
    output logic [EW-1:0]                 o_ram_wdata,
    output logic                          o_ram_re,
    output logic [$clog2(DEPTH)-1:0]      o_ram_raddr,
    input  wire logic [EW-1:0]            i_ram_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);

    // Entry layout: position, marks, chrom, tag from bit 0 up
    localparam int OFS_MK  = PB;
    localparam int OFS_CHR = PB + 4;
    localparam int OFS_TAG = PB + 12;

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CPG   = 3'd1;
    localparam logic [2:0] S_INS   = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_FRONT = 3'd4;
    localparam logic [2:0] S_SCAN  = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_head;
    logic [FW-1:0] r_fill;
    logic [FW-1:0] r_limit;
    logic [FW-1:0] r_iss;
    logic          r_pend;

    // Captured input record
    logic [PB-1:0] r_in_pos;
    logic [7:0]    r_in_chr;
    logic [3:0]    r_in_mk;
    logic [31:0]   r_in_tag;
    logic          r_in_eos;

    // Record being released
    logic [PB-1:0] r_f_pos;
    logic [7:0]    r_f_chr;
    logic [31:0]   r_f_tag;
    logic [3:0]    r_f_mk;
    logic          r_close;

    // Last released indel
    logic [PB-1:0] r_bh_pos;
    logic [7:0]    r_bh_chr;
    logic          r_bh_seen;

    // Result register
    logic          r_out_valid;
    t_rec_out      r_out;

    logic [PB-1:0] rd_pos;
    logic [3:0]    rd_mk;
    logic [7:0]    rd_chr;
    logic [31:0]   rd_tag;
    logic          in_acc;
    logic          cpg_pair;
    logic          scan_hit;
    logic          behind_hit;
    logic          emit_go;
    logic          rel_need;
    logic [FW-1:0] n_limit;

    // Ring slot of the i-th held record
    function automatic logic [AW-1:0] f_slot(input logic [AW-1:0] head,
                                             input logic [FW-1:0] idx);
        logic [FW:0] s;
        s = (FW+1)'(head) + (FW+1)'(idx);
        if (s >= (FW+1)'(DEPTH)) begin
            s = s - (FW+1)'(DEPTH);
        end
        return AW'(s);
    endfunction

    // to lies 0..read_ahead positions after from, modulo position width
    function automatic logic f_near(input logic [PB-1:0] from,
                                    input logic [PB-1:0] to,
                                    input logic [3:0]    ra);
        logic [PB-1:0] d;
        d = to - from;
        return d <= PB'(ra);
    endfunction

    // Unpack memory read data
    assign rd_pos = i_ram_rdata[PB-1:0];
    assign rd_mk  = i_ram_rdata[OFS_MK +: 4];
    assign rd_chr = i_ram_rdata[OFS_CHR +: 8];
    assign rd_tag = i_ram_rdata[OFS_TAG +: 32];

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;

    assign cpg_pair = (rd_pos + PB'(1) == r_in_pos) && (rd_chr == r_in_chr) &&
                      rd_mk[MK_C] && r_in_mk[MK_G];
    assign scan_hit = r_pend && rd_mk[MK_INDEL] && (rd_chr == r_f_chr) &&
                      f_near(r_f_pos, rd_pos, i_read_ahead);
    assign behind_hit = r_bh_seen && (r_bh_chr == r_f_chr) &&
                        f_near(r_bh_pos, r_f_pos, i_read_ahead);
    assign emit_go  = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);
    assign rel_need = (r_fill > r_limit);

    // Hold limit for the record just inserted
    always_comb begin
        if (32'(i_read_ahead) + 32'd1 > 32'(DEPTH - 1)) begin
            n_limit = FW'(DEPTH - 1);
        end else begin
            n_limit = FW'(32'(i_read_ahead) + 32'd1);
        end
        if (r_in_eos) begin
            n_limit = '0;
        end
    end

    // Memory port control and next state
    always_comb begin
        o_ram_we    = 1'b0;
        o_ram_waddr = f_slot(r_head, r_fill);
        o_ram_wdata = {r_in_tag, r_in_chr, r_in_mk, r_in_pos};
        o_ram_re    = 1'b0;
        o_ram_raddr = r_head;
        n_state     = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (r_fill != '0) begin
                        o_ram_re    = 1'b1;
                        o_ram_raddr = f_slot(r_head, r_fill - FW'(1));
                        n_state     = S_CPG;
                    end else begin
                        n_state = S_INS;
                    end
                end
            end
            S_CPG: begin
                // mark the newest held record in place
                if (cpg_pair) begin
                    o_ram_we    = 1'b1;
                    o_ram_waddr = f_slot(r_head, r_fill - FW'(1));
                    o_ram_wdata = {rd_tag, rd_chr, rd_mk | 4'(1 << MK_CPG), rd_pos};
                end
                n_state = S_INS;
            end
            S_INS: begin
                o_ram_we = 1'b1;
                n_state  = S_CHECK;
            end
            S_CHECK: begin
                if (rel_need) begin
                    o_ram_re = 1'b1;
                    n_state  = S_FRONT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FRONT: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_iss < r_fill) begin
                    o_ram_re    = 1'b1;
                    o_ram_raddr = f_slot(r_head, r_iss);
                end else if (!r_pend) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (emit_go) begin
                    n_state = S_CHECK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_fill    <= '0;
            r_limit   <= '0;
            r_iss     <= '0;
            r_pend    <= 1'b0;
            r_bh_seen <= 1'b0;
            r_bh_pos  <= '0;
            r_bh_chr  <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_INS: begin
                    r_fill  <= r_fill + FW'(1);
                    r_limit <= n_limit;
                end
                S_FRONT: begin
                    r_head <= f_slot(r_head, FW'(1));
                    r_fill <= r_fill - FW'(1);
                    r_iss  <= '0;
                    r_pend <= 1'b0;
                end
                S_SCAN: begin
                    r_pend <= (r_iss < r_fill);
                    if (r_iss < r_fill) begin
                        r_iss <= r_iss + FW'(1);
                    end
                end
                S_EMIT: begin
                    if (emit_go && r_f_mk[MK_INDEL]) begin
                        r_bh_seen <= 1'b1;
                        r_bh_pos  <= r_f_pos;
                        r_bh_chr  <= r_f_chr;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Record payload
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_in_pos <= PB'(i_rec.position);
                    r_in_chr <= i_rec.chrom_id;
                    r_in_mk  <= {1'b0, i_rec.is_indel, i_rec.has_g, i_rec.has_c};
                    r_in_tag <= i_rec.record_tag;
                    r_in_eos <= i_rec.end_of_stream;
                end
            end
            S_CPG: begin
                if (cpg_pair) begin
                    r_in_mk[MK_CPG] <= 1'b1;
                end
            end
            S_FRONT: begin
                r_f_pos <= rd_pos;
                r_f_chr <= rd_chr;
                r_f_tag <= rd_tag;
                r_f_mk  <= rd_mk;
                r_close <= rd_mk[MK_INDEL];
            end
            S_SCAN: begin
                if (scan_hit) begin
                    r_close <= 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_go) begin
            r_out.out_position     <= 32'(r_f_pos);
            r_out.out_chrom_id     <= r_f_chr;
            r_out.out_tag          <= r_f_tag;
            r_out.out_is_indel     <= r_f_mk[MK_INDEL];
            r_out.cpg_flag         <= r_f_mk[MK_CPG];
            r_out.close_indel_flag <= r_close || behind_hit;
            r_out.last_of_run      <= (r_fill <= r_limit);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_rec       = r_out;

endmodule

`default_nettype wire

[rtl/variant_window_cpg_indel_flagger.sv]
// Each item is checked for a CpG pair against the newest held record (skipped with an empty
// window) and stored; then each released record is read, scanned against the records still
// held after it and emitted. The input is taken only between items, so a new item waits until
// the last one is through; a result may wait in the output register.
// Reset (synchronous, active low) empties the window, forgets the last indel and sets
// read_ahead to 5; window memory contents are not cleared and need no clearing pass.
`default_nettype none

module variant_window_cpg_indel_flagger
    import vwcif_pkg::*;
#(
    parameter int WINDOW_DEPTH  = WINDOW_DEPTH_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // input records
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // position[31:0], chrom_id[39:32], has_c[40], has_g[41], is_indel[42],
    // record_tag[74:43], zero[79:75]
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    input  wire logic                   i_s_axis_tlast,   // end_of_stream
    // released records
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // out_position[31:0], out_chrom_id[39:32], out_tag[71:40], out_is_indel[72],
    // cpg_flag[73], close_indel_flag[74], zero[79:75]
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata,
    output logic                        o_m_axis_tlast,   // last_of_run
    // read_ahead register write
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [3:0]             i_cfg_data
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int EW = POSITION_BITS + 44;

    logic [3:0]    r_read_ahead;
    t_rec_in       in_rec;
    t_rec_out      out_rec;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;

    // Configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_ahead <= READ_AHEAD_RST;
        end else if (i_cfg_valid) begin
            r_read_ahead <= i_cfg_data;
        end
    end

    // Unpack input beat
    assign in_rec.position      = i_s_axis_tdata[31:0];
    assign in_rec.chrom_id      = i_s_axis_tdata[39:32];
    assign in_rec.has_c         = i_s_axis_tdata[40];
    assign in_rec.has_g         = i_s_axis_tdata[41];
    assign in_rec.is_indel      = i_s_axis_tdata[42];
    assign in_rec.record_tag    = i_s_axis_tdata[74:43];
    assign in_rec.end_of_stream = i_s_axis_tlast;

    // Pack output beat
    assign o_m_axis_tdata = {5'd0, out_rec.close_indel_flag, out_rec.cpg_flag,
                             out_rec.out_is_indel, out_rec.out_tag,
                             out_rec.out_chrom_id, out_rec.out_position};
    assign o_m_axis_tlast = out_rec.last_of_run;

    vwcif_ctrl #(
        .DEPTH (WINDOW_DEPTH),
        .PB    (POSITION_BITS),
        .EW    (EW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_read_ahead (r_read_ahead),
        .i_in_valid   (i_s_axis_tvalid),
        .o_in_ready   (o_s_axis_tready),
        .i_rec        (in_rec),
        .o_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .o_rec        (out_rec),
        .o_ram_we     (ram_we),
        .o_ram_waddr  (ram_waddr),
        .o_ram_wdata  (ram_wdata),
        .o_ram_re     (ram_re),
        .o_ram_raddr  (ram_raddr),
        .i_ram_rdata  (ram_rdata)
    );

    vwcif_window_ram #(
        .DEPTH (WINDOW_DEPTH),
        .WIDTH (EW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

`default_nettype wire

[tb/sv/variant_window_cpg_indel_flagger_tb.sv]
// Self-checking testbench for the variant window CpG / indel flagger.
`timescale 1ns / 1ps

module variant_window_cpg_indel_flagger_tb;
    import vwcif_pkg::*;

    localparam int DEPTH       = WINDOW_DEPTH_DEF;
    localparam int SETTLE      = 40;       // wait for a record with no release to finish
    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_ITEMS  = 150;

    typedef enum logic {ROW_CFG, ROW_REC} t_row_kind;

    // One line of the directed plan; want_* is checked on the row's last release
    typedef struct {
        t_row_kind   kind;
        logic [3:0]  ahead;
        t_rec_in     rec;
        bit          typed;
        bit          want_cpg;
        bit          want_close;
    } t_plan_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;
    logic                   i_s_axis_tlast;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   o_m_axis_tlast;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [3:0]             i_cfg_data;

    variant_window_cpg_indel_flagger dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Window predictor state
    logic [31:0] win_pos [DEPTH];
    logic [7:0]  win_chr [DEPTH];
    logic [31:0] win_tag [DEPTH];
    logic [3:0]  win_mk  [DEPTH];
    int          win_head;
    int          win_fill;
    logic [31:0] back_indel_pos;
    logic [7:0]  back_indel_chr;
    bit          back_indel_seen;
    logic [3:0]  ahead_cfg;

    t_rec_out    due_releases[$];
    t_plan_row   plan[$];
    int          n_errors;
    int          n_records;
    int          n_released;
    int          n_cfg_writes;
    int          cycle_count;
    bit          quiet;

    // Append one predicted release at the tail of the queue
    function automatic void queue_release(input t_rec_out o);
        due_releases.insert(due_releases.size(), o);
    endfunction

    // Append one row to the directed plan
    function automatic void add_row(input t_plan_row p);
        plan.insert(plan.size(), p);
    endfunction

    // Release the oldest held record and work out its marks
    function automatic t_rec_out release_oldest();
        t_rec_out    o;
        int          slot;
        int          t;
        logic [31:0] pos;
        logic [31:0] gap;
        logic [7:0]  chr;
        logic [3:0]  mk;
        bit          close;
        slot = win_head;
        pos  = win_pos[slot];
        chr  = win_chr[slot];
        mk   = win_mk[slot];
        close = mk[MK_INDEL];
        win_head = (win_head + 1) % DEPTH;
        win_fill--;
        // any held later indel ahead on the same chromosome
        for (int i = 0; i < win_fill; i++) begin
            t = (win_head + i) % DEPTH;
            gap = win_pos[t] - pos;
            if (win_mk[t][MK_INDEL] && win_chr[t] == chr && gap <= ahead_cfg)
                close = 1'b1;
        end
        // last released indel behind it
        gap = pos - back_indel_pos;
        if (back_indel_seen && back_indel_chr == chr && gap <= ahead_cfg)
            close = 1'b1;
        if (mk[MK_INDEL]) begin
            back_indel_seen = 1'b1;
            back_indel_pos  = pos;
            back_indel_chr  = chr;
        end
        o.out_position     = pos;
        o.out_chrom_id     = chr;
        o.out_tag          = win_tag[slot];
        o.out_is_indel     = mk[MK_INDEL];
        o.cpg_flag         = mk[MK_CPG];
        o.close_indel_flag = close;
        o.last_of_run      = 1'b0;
        return o;
    endfunction

    // Take one record into the window and queue every release it causes
    task automatic flag_record(input t_rec_in r);
        logic [3:0]  mk;
        logic [31:0] next_pos;
        t_rec_out    o;
        int          newest;
        int          slot;
        int          limit;
        int          n;
        mk = '0;
        mk[MK_C]     = r.has_c;
        mk[MK_G]     = r.has_g;
        mk[MK_INDEL] = r.is_indel;
        if (win_fill > 0) begin
            newest   = (win_head + win_fill - 1) % DEPTH;
            next_pos = win_pos[newest] + 32'd1;
            if (next_pos == r.position && win_chr[newest] == r.chrom_id &&
                win_mk[newest][MK_C] && mk[MK_G]) begin
                win_mk[newest][MK_CPG] = 1'b1;
                mk[MK_CPG] = 1'b1;
            end
        end
        slot = (win_head + win_fill) % DEPTH;
        win_pos[slot] = r.position;
        win_chr[slot] = r.chrom_id;
        win_tag[slot] = r.record_tag;
        win_mk[slot]  = mk;
        win_fill++;
        limit = int'(ahead_cfg) + 1;
        if (limit > DEPTH - 1)
            limit = DEPTH - 1;
        if (r.end_of_stream)
            limit = 0;
        n = 0;
        while (win_fill > limit) begin
            queue_release(release_oldest());
            n++;
        end
        if (n > 0) begin
            o = due_releases[due_releases.size() - 1];
            o.last_of_run = 1'b1;
            due_releases[due_releases.size() - 1] = o;
        end
    endtask

    // Send one record beat; prediction happens on acceptance
    task automatic send_record(input t_rec_in r);
        while (!quiet && $urandom_range(99) < 8) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = {5'b0, r.record_tag, r.is_indel, r.has_g, r.has_c,
                           r.chrom_id, r.position};
        i_s_axis_tlast  = r.end_of_stream;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        flag_record(r);
        n_records++;
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
    endtask

    // Hold off until every release has come out and the block has settled
    task automatic wait_drain();
        while (due_releases.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Write read_ahead while the block is idle
    task automatic write_ahead(input logic [3:0] v);
        wait_drain();
        i_cfg_valid = 1'b1;
        i_cfg_data  = v;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        ahead_cfg = v;
        n_cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic t_plan_row cfg_row(input logic [3:0] v);
        t_plan_row p;
        p.kind       = ROW_CFG;
        p.ahead      = v;
        p.rec        = '0;
        p.typed      = 1'b0;
        p.want_cpg   = 1'b0;
        p.want_close = 1'b0;
        return p;
    endfunction

    function automatic t_plan_row rec_row(input logic [31:0] pos, input logic [7:0] chr,
                                          input bit c, input bit g, input bit ind,
                                          input logic [31:0] tag, input bit eos,
                                          input bit typed, input bit cpg, input bit close);
        t_plan_row p;
        p.kind                = ROW_REC;
        p.ahead               = '0;
        p.rec.position        = pos;
        p.rec.chrom_id        = chr;
        p.rec.has_c           = c;
        p.rec.has_g           = g;
        p.rec.is_indel        = ind;
        p.rec.record_tag      = tag;
        p.rec.end_of_stream   = eos;
        p.typed               = typed;
        p.want_cpg            = cpg;
        p.want_close          = close;
        return p;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, what, want, got);
            n_errors++;
        end
    endtask

    // Result side: compare each released record with the oldest prediction
    t_rec_out want_out;
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (due_releases.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual tdata 0x%0h tlast %0b",
                         $time, o_m_axis_tdata, o_m_axis_tlast);
                n_errors++;
            end else begin
                want_out = due_releases[0];
                due_releases.delete(0);
                check_field("out_position", want_out.out_position, o_m_axis_tdata[31:0]);
                check_field("out_chrom_id", 32'(want_out.out_chrom_id),
                            32'(o_m_axis_tdata[39:32]));
                check_field("out_tag", want_out.out_tag, o_m_axis_tdata[71:40]);
                check_field("out_is_indel", 32'(want_out.out_is_indel),
                            32'(o_m_axis_tdata[72]));
                check_field("cpg_flag", 32'(want_out.cpg_flag), 32'(o_m_axis_tdata[73]));
                check_field("close_indel_flag", 32'(want_out.close_indel_flag),
                            32'(o_m_axis_tdata[74]));
                check_field("last_of_run", 32'(want_out.last_of_run), 32'(o_m_axis_tlast));
                n_released++;
            end
        end
    end

    // Result-side backpressure
    always @(negedge i_clk)
        i_m_axis_tready <= quiet || ($urandom_range(99) >= 8);

    // Run-away guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        t_rec_in     r;
        t_rec_out    o;
        t_plan_row   p;
        logic [7:0]  cur_chr;
        logic [31:0] cur_pos;
        logic [3:0]  v;

        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tlast  = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = '0;
        cycle_count     = 0;
        n_errors        = 0;
        n_records       = 0;
        n_released      = 0;
        n_cfg_writes    = 0;
        quiet           = 1'b0;
        win_head        = 0;
        win_fill        = 0;
        back_indel_pos  = '0;
        back_indel_chr  = '0;
        back_indel_seen = 1'b0;
        ahead_cfg       = READ_AHEAD_RST;

        // Directed plan: CpG pair, indel self / ahead / behind, flush,
        // position wrap, extreme fields, read_ahead lowered with records held
        add_row(cfg_row(4'd0));
        add_row(rec_row(32'd100, 8'd1, 1, 0, 0, 32'h0000_0001, 0, 0, 0, 0));
        add_row(rec_row(32'd101, 8'd1, 0, 1, 0, 32'h0000_0002, 0, 1, 1, 0));
        add_row(rec_row(32'd101, 8'd1, 0, 0, 1, 32'h0000_0003, 0, 1, 1, 1));
        add_row(rec_row(32'd102, 8'd1, 0, 0, 0, 32'h0000_0004, 0, 1, 0, 1));
        add_row(rec_row(32'd103, 8'd2, 0, 0, 0, 32'h0000_0005, 1, 1, 0, 0));
        add_row(cfg_row(4'd14));
        add_row(rec_row(32'hFFFF_FFFF, 8'd255, 1, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0));
        add_row(rec_row(32'h0000_0000, 8'd255, 0, 1, 1, 32'h0000_0000, 0, 0, 0, 0));
        add_row(rec_row(32'hFFFF_FFF0, 8'd255, 0, 0, 0, 32'h5A5A_5A5A, 0, 0, 0, 0));
        add_row(cfg_row(4'd1));
        add_row(rec_row(32'd5, 8'd255, 1, 0, 0, 32'hA5A5_A5A5, 0, 1, 1, 1));
        add_row(rec_row(32'd6, 8'd255, 0, 1, 0, 32'h1234_5678, 1, 1, 1, 0));
        add_row(cfg_row(4'd3));
        add_row(rec_row(32'd7, 8'd255, 1, 1, 0, 32'h8765_4321, 0, 0, 0, 0));
        add_row(rec_row(32'd8, 8'd255, 0, 1, 1, 32'h0F0F_0F0F, 0, 0, 0, 0));
        add_row(rec_row(32'd12, 8'd255, 0, 0, 1, 32'hF0F0_F0F0, 0, 0, 0, 0));
        add_row(rec_row(32'd20, 8'd7, 1, 0, 0, 32'hDEAD_0001, 0, 0, 0, 0));
        add_row(rec_row(32'd21, 8'd7, 0, 1, 0, 32'hDEAD_0002, 1, 0, 0, 0));

        // Hold reset, then release it
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (plan[i]) begin
            p = plan[i];
            if (p.kind == ROW_CFG) begin
                write_ahead(p.ahead);
            end else begin
                send_record(p.rec);
                // hand-worked marks replace the predicted ones on the last release
                if (p.typed && due_releases.size() != 0) begin
                    o = due_releases[due_releases.size() - 1];
                    o.cpg_flag         = p.want_cpg;
                    o.close_indel_flag = p.want_close;
                    due_releases[due_releases.size() - 1] = o;
                end
            end
        end

        // Random part: mostly sorted runs with random content, some noise
        cur_chr = 8'($urandom_range(255));
        cur_pos = $urandom;
        for (int k = 0; k < RAND_ITEMS; k++) begin
            if (k > 0 && k % 40 == 0) begin
                case (k / 40)
                    1:       v = 4'd14;
                    2:       v = 4'd0;
                    default: v = 4'($urandom_range(14));
                endcase
                write_ahead(v);
            end
            quiet = (k >= 60 && k < 110);
            if ($urandom_range(99) < 85) begin
                if ($urandom_range(99) < 12) begin
                    cur_chr = 8'($urandom_range(255));
                    if ($urandom_range(7) == 0)
                        cur_pos = 32'hFFFF_FFFF - 32'($urandom_range(3));
                    else
                        cur_pos = $urandom;
                end else begin
                    cur_pos = cur_pos + 32'($urandom_range(3));
                end
                r.position      = cur_pos;
                r.chrom_id      = cur_chr;
                r.has_c         = 1'($urandom_range(1));
                r.has_g         = 1'($urandom_range(1));
                r.is_indel      = ($urandom_range(99) < 20);
                r.record_tag    = $urandom;
                r.end_of_stream = ($urandom_range(99) < 4);
            end else begin
                r.position      = $urandom;
                r.chrom_id      = 8'($urandom_range(255));
                r.has_c         = 1'($urandom_range(1));
                r.has_g         = 1'($urandom_range(1));
                r.is_indel      = 1'($urandom_range(1));
                r.record_tag    = $urandom;
                r.end_of_stream = ($urandom_range(99) < 10);
            end
            // close the stream so everything held comes out
            if (k == RAND_ITEMS - 1)
                r.end_of_stream = 1'b1;
            send_record(r);
        end
        quiet = 1'b0;

        wait_drain();

        $display("Run covered %0d input records and %0d released records",
                 n_records, n_released);
        $display("over %0d read_ahead writes, with CpG pairs, indel proximity both ways, %s",
                 n_cfg_writes, "position wrap and flushes");
        if (n_errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
